### rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// shared constants and types for the text console cell writer
// ----------------------------------------------------------------------------
package tccw_pkg;

	// screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	// field widths
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CHAR_W = 8;
	localparam int CLR_W  = 4;
	localparam int CELL_W = 16;

	localparam int TAB_STOP = 8;
	localparam int TAB_W    = $clog2(TAB_STOP) + 1;

	// character codes
	localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;

	typedef enum logic [1:0] {
		CMD_PUT_CHAR = 2'd0,
		CMD_PUT_AT   = 2'd1,
		CMD_CLEAR    = 2'd2,
		CMD_READ     = 2'd3
	} cmd_t;

	// configuration register indexes
	typedef enum logic {
		REG_FG = 1'b0,
		REG_BG = 1'b1
	} reg_idx_t;

endpackage

### rtl/text_console_cell_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit
// teletype text console over a single-port-read character cell store
// put_at, ignored bytes and bad addresses finish from the idle state; printable bytes, read,
//   backspace, newline and tab pass through the sequencer; a row-end wrap adds a newline,
//   a scroll adds the row copy and a blank bottom row, clear blanks the whole store
// one command at a time; the scroll copy loop reads then writes each cell
// results cannot be stalled: done strobes for one cycle
// after reset a clearing pass zeroes the whole store while busy stays high
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// command beat
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  command,
	input  logic [tccw_pkg::CHAR_W-1:0] char_code,
	input  logic [tccw_pkg::ROW_W-1:0]  row,
	input  logic [tccw_pkg::COL_W-1:0]  col,
	// result beat
	output logic                        done,
	output logic [tccw_pkg::CELL_W-1:0] cell_value,
	output logic [tccw_pkg::ROW_W-1:0]  cursor_row,
	output logic [tccw_pkg::COL_W-1:0]  cursor_col,
	// configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [tccw_pkg::CLR_W-1:0]  cfg_data
);
	import tccw_pkg::*;

	// sequencer states
	typedef enum logic [9:0] {
		ST_INIT    = 10'b00_0000_0001, // post-reset zeroing sweep
		ST_IDLE    = 10'b00_0000_0010,
		ST_PRINT   = 10'b00_0000_0100, // write one byte at the cursor, advance
		ST_NEWLINE = 10'b00_0000_1000,
		ST_SCR_RD  = 10'b00_0001_0000, // fetch cell one row below
		ST_SCR_WR  = 10'b00_0010_0000, // write it back one row up
		ST_FILL    = 10'b00_0100_0000, // blank a range up to the store end
		ST_NEXT    = 10'b00_1000_0000, // more tab padding or finish
		ST_BS      = 10'b01_0000_0000, // blank under the moved cursor
		ST_RESP    = 10'b10_0000_0000  // read data back from the store
	} state_t;

	localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] SCR_LAST    = ADDR_W'(CELL_COUNT - COLUMNS - 1);
	localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'(CELL_COUNT - COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
	localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

	state_t               state_q;
	logic [ADDR_W-1:0]    addr_q;     // sweep / scroll pointer
	logic [ROW_W-1:0]     line_q;
	logic [COL_W-1:0]     column_q;
	logic [TAB_W-1:0]     tab_q;      // bytes still to print
	logic [CHAR_W-1:0]    pend_q;     // byte to print
	logic [CLR_W-1:0]     fg_q;
	logic [CLR_W-1:0]     bg_q;
	logic                 done_q;
	logic [CELL_W-1:0]    value_q;

	// cell store
	logic [CELL_W-1:0]    mem [CELL_COUNT];
	logic [CELL_W-1:0]    rdata_q;
	logic                 we;
	logic [ADDR_W-1:0]    waddr;
	logic [ADDR_W-1:0]    raddr;
	logic [CELL_W-1:0]    wdata;

	logic                 accept;
	cmd_t                 cmd;
	logic                 in_range;
	logic [ADDR_W-1:0]    in_addr;
	logic [ADDR_W-1:0]    cur_addr;
	logic [CELL_W-1:0]    blank_cell;
	logic [CELL_W-1:0]    in_cell;
	logic [CELL_W-1:0]    pend_cell;
	logic [COL_W:0]       col_inc;
	logic [COL_W-1:0]     col_back;
	logic                 printable;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign cmd       = cmd_t'(command);

	assign in_range = ({1'b0, row} < (ROW_W+1)'(ROWS)) && ({1'b0, col} < (COL_W+1)'(COLUMNS));
	// row base by a constant multiplier, then the column
	assign in_addr  = ADDR_W'(ADDR_W'(row) * ROW_STRIDE) + ADDR_W'(col);
	assign cur_addr = ADDR_W'(ADDR_W'(line_q) * ROW_STRIDE) + ADDR_W'(column_q);

	assign blank_cell = {bg_q, fg_q, CH_BLANK};
	assign in_cell    = {bg_q, fg_q, char_code};
	assign pend_cell  = {bg_q, fg_q, pend_q};

	assign col_inc   = {1'b0, column_q} + (COL_W+1)'(1);
	assign col_back  = (column_q != '0) ? column_q - COL_W'(1) : column_q;
	assign printable = (char_code >= CH_BLANK) && (char_code < CH_DEL);

	// store port selection
	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = blank_cell;
		raddr = in_addr;
		unique case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				wdata = '0;
			end
			ST_IDLE: begin
				// put_at writes straight from the command beat
				we    = accept && (cmd == CMD_PUT_AT) && in_range;
				waddr = in_addr;
				wdata = in_cell;
			end
			ST_PRINT: begin
				we    = 1'b1;
				waddr = cur_addr;
				wdata = pend_cell;
			end
			ST_BS: begin
				we    = 1'b1;
				waddr = cur_addr;
			end
			ST_SCR_RD: begin
				raddr = addr_q + ROW_STRIDE;
			end
			ST_SCR_WR: begin
				we    = 1'b1;
				wdata = rdata_q;
			end
			ST_FILL: begin
				we = 1'b1;
			end
			ST_NEWLINE, ST_NEXT, ST_RESP: begin
				we = 1'b0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= 4'hF;
			bg_q <= 4'h0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FG:  fg_q <= cfg_data;
				REG_BG:  bg_q <= cfg_data;
				default: fg_q <= fg_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			addr_q   <= '0;
			line_q   <= '0;
			column_q <= '0;
			tab_q    <= '0;
			pend_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						tab_q <= '0;
						case (cmd)
							CMD_PUT_CHAR: begin
								if (printable) begin
									pend_q  <= char_code;
									tab_q   <= TAB_W'(1);
									state_q <= ST_PRINT;
								end else if (char_code == CH_TAB) begin
									pend_q  <= CH_BLANK;
									tab_q   <= TAB_W'(TAB_STOP) - TAB_W'(column_q[2:0]);
									state_q <= ST_PRINT;
								end else if (char_code == CH_NL) begin
									state_q <= ST_NEWLINE;
								end else if (char_code == CH_BS) begin
									column_q <= col_back;
									state_q  <= ST_BS;
								end else begin
									// ignored byte
									done_q <= 1'b1;
								end
							end
							CMD_CLEAR: begin
								addr_q   <= '0;
								line_q   <= '0;
								column_q <= '0;
								state_q  <= ST_FILL;
							end
							CMD_READ: begin
								if (in_range) begin
									state_q <= ST_RESP;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								// put_at, already written
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_PRINT: begin
					tab_q <= tab_q - TAB_W'(1);
					if (col_inc == (COL_W+1)'(COLUMNS)) begin
						state_q <= ST_NEWLINE;
					end else begin
						column_q <= col_inc[COL_W-1:0];
						if (tab_q == TAB_W'(1)) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_NEWLINE: begin
					column_q <= '0;
					if (line_q == LAST_ROW) begin
						addr_q  <= '0;
						state_q <= ST_SCR_RD;
					end else begin
						line_q  <= line_q + ROW_W'(1);
						state_q <= ST_NEXT;
					end
				end
				ST_SCR_RD: begin
					state_q <= ST_SCR_WR;
				end
				ST_SCR_WR: begin
					if (addr_q == SCR_LAST) begin
						// copy finished, blank the bottom row
						addr_q  <= BOTTOM_BASE;
						state_q <= ST_FILL;
					end else begin
						addr_q  <= addr_q + ADDR_W'(1);
						state_q <= ST_SCR_RD;
					end
				end
				ST_FILL: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (tab_q != '0) begin
						state_q <= ST_PRINT;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_BS: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_RESP: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload: read data only after a read, zero otherwise
	always_ff @(posedge clk) begin
		value_q <= (state_q == ST_RESP) ? rdata_q : '0;
	end

	assign done       = done_q;
	assign cell_value = value_q;
	assign cursor_row = line_q;
	assign cursor_col = column_q;

endmodule

### tb/sv/text_console_cell_writer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit_tb
// self-checking bench for the teletype text console: a shadow screen and
// cursor predict every done beat, which is checked field by field; directed
// cases cover printable, control and ignored bytes, put_at, read, clear, row
// wrap and scroll, then random traffic runs under three sender idle profiles
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit_tb;

	import tccw_pkg::*;

	// one expected done beat
	typedef struct packed {
		logic [CELL_W-1:0] value;
		logic [ROW_W-1:0]  crow;
		logic [COL_W-1:0]  ccol;
	} console_beat_t;

	// a scroll reads and writes nearly every cell of the store, so allow a few of them per drain
	localparam int DRAIN_LIMIT = 20000;
	localparam int TAIL_CYCLES = 16;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic              busy;
	logic [1:0]        command   = CMD_PUT_CHAR;
	logic [CHAR_W-1:0] char_code = '0;
	logic [ROW_W-1:0]  row       = '0;
	logic [COL_W-1:0]  col       = '0;
	logic              done;
	logic [CELL_W-1:0] cell_value;
	logic [ROW_W-1:0]  cursor_row;
	logic [COL_W-1:0]  cursor_col;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = REG_FG;
	logic [CLR_W-1:0]  cfg_data  = '0;

	// shadow of the block: screen contents, cursor and colours
	logic [CELL_W-1:0] screen_shadow [CELL_COUNT];
	int unsigned       cur_line   = 0;
	int unsigned       cur_column = 0;
	logic [CLR_W-1:0]  fg_shadow  = 4'hF;
	logic [CLR_W-1:0]  bg_shadow  = 4'h0;

	console_beat_t pending_beats [$];
	int            error_count   = 0;
	int            send_idle_pct = 0;
	int            items_sent    = 0;

	text_console_cell_writer_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.char_code  (char_code),
		.row        (row),
		.col        (col),
		.done       (done),
		.cell_value (cell_value),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// screen prediction
	// ------------------------------------------------------------------

	// attribute byte is background in the high nibble, foreground low
	function automatic logic [CELL_W-1:0] attr_cell(logic [CHAR_W-1:0] ch);
		return {bg_shadow, fg_shadow, ch};
	endfunction

	// writes outside the screen fall away silently
	function automatic void poke_cell(int unsigned r, int unsigned c, logic [CHAR_W-1:0] ch);
		if (r < ROWS && c < COLUMNS)
			screen_shadow[r * COLUMNS + c] = attr_cell(ch);
	endfunction

	// newline: next row, and scroll up with a blank bottom row when off the end
	function automatic void line_feed();
		cur_column = 0;
		cur_line++;
		if (cur_line >= ROWS) begin
			for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
				screen_shadow[i] = screen_shadow[i + COLUMNS];
			cur_line = ROWS - 1;
			for (int c = 0; c < COLUMNS; c++)
				poke_cell(cur_line, c, CH_BLANK);
		end
	endfunction

	// printable byte at the cursor, wrapping at the row end
	function automatic void print_glyph(logic [CHAR_W-1:0] ch);
		poke_cell(cur_line, cur_column, ch);
		cur_column++;
		if (cur_column >= COLUMNS)
			line_feed();
	endfunction

	// applies one command beat to the shadow and returns the done beat it causes
	function automatic console_beat_t console_step(cmd_t cmd, logic [CHAR_W-1:0] ch,
			logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		console_beat_t beat;
		int unsigned   pad;
		beat.value = '0;
		case (cmd)
			CMD_PUT_CHAR: begin
				if (ch >= CH_BLANK && ch < CH_DEL) begin
					print_glyph(ch);
				end else if (ch == CH_NL) begin
					line_feed();
				end else if (ch == CH_BS) begin
					// never climbs to the previous row, but still blanks the cell
					if (cur_column > 0)
						cur_column--;
					poke_cell(cur_line, cur_column, CH_BLANK);
				end else if (ch == CH_TAB) begin
					// each pad blank may wrap or scroll on its own
					pad = TAB_STOP - (cur_column % TAB_STOP);
					repeat (pad)
						print_glyph(CH_BLANK);
				end
				// any other byte leaves everything as it was
			end
			CMD_PUT_AT: begin
				poke_cell(r, c, ch);
			end
			CMD_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++)
					screen_shadow[i] = attr_cell(CH_BLANK);
				cur_line   = 0;
				cur_column = 0;
			end
			default: begin
				// read beyond the screen reports zero
				if (r < ROWS && c < COLUMNS)
					beat.value = screen_shadow[r * COLUMNS + c];
			end
		endcase
		beat.crow = ROW_W'(cur_line);
		beat.ccol = COL_W'(cur_column);
		return beat;
	endfunction

	// ------------------------------------------------------------------
	// result checking: every done beat against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		console_beat_t want;
		if (arst_n && done !== 1'b0) begin
			if (pending_beats.size() == 0) begin
				$error("done beat with no result expected");
				error_count++;
			end else begin
				want = pending_beats.pop_front();
				if (cell_value !== want.value) begin
					$error("cell_value expected %h, got %h", want.value, cell_value);
					error_count++;
				end
				if (cursor_row !== want.crow) begin
					$error("cursor_row expected %0d, got %0d", want.crow, cursor_row);
					error_count++;
				end
				if (cursor_col !== want.ccol) begin
					$error("cursor_col expected %0d, got %0d", want.ccol, cursor_col);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// one command beat; start may stay high into the next call for back-to-back beats
	task automatic send_cmd(cmd_t cmd, logic [CHAR_W-1:0] ch, logic [ROW_W-1:0] r,
			logic [COL_W-1:0] c);
		if ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		start     <= 1'b1;
		command   <= cmd;
		char_code <= ch;
		row       <= r;
		col       <= c;
		// accepted at the first edge that sees busy low
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_beats.push_back(console_step(cmd, ch, r, c));
		items_sent++;
	endtask

	// hold off until every expected beat is in and the block is idle
	task automatic wait_for_quiet();
		int waited;
		waited = 0;
		start <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while ((pending_beats.size() != 0 || busy) && waited < DRAIN_LIMIT);
		if (pending_beats.size() != 0) begin
			$error("%0d expected results never arrived", pending_beats.size());
			error_count++;
			pending_beats.delete();
		end
	endtask

	// register write, only ever with the block idle
	task automatic write_reg(reg_idx_t idx, logic [CLR_W-1:0] val);
		wait_for_quiet();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FG: fg_shadow = val;
			REG_BG: bg_shadow = val;
		endcase
	endtask

	// mostly on-screen addresses, now and then anywhere in the field range
	function automatic logic [ROW_W-1:0] pick_row();
		return ($urandom_range(9) == 0) ? ROW_W'($urandom_range(31))
			: ROW_W'($urandom_range(ROWS - 1));
	endfunction

	function automatic logic [COL_W-1:0] pick_col();
		return ($urandom_range(9) == 0) ? COL_W'($urandom_range(127))
			: COL_W'($urandom_range(COLUMNS - 1));
	endfunction

	// one random beat, weighted towards text so the cursor walks the screen;
	// newline bursts are kept rare since each scroll copies nearly the whole store
	task automatic send_random();
		int unsigned      w;
		logic [ROW_W-1:0] any_row;
		logic [COL_W-1:0] any_col;
		w       = $urandom_range(999);
		any_row = ROW_W'($urandom_range(31));
		any_col = COL_W'($urandom_range(127));
		if (w < 560)
			send_cmd(CMD_PUT_CHAR, CHAR_W'($urandom_range(8'h7E, 8'h20)), any_row, any_col);
		else if (w < 590)
			send_cmd(CMD_PUT_CHAR, CH_NL, any_row, any_col);
		else if (w < 620)
			send_cmd(CMD_PUT_CHAR, CH_TAB, any_row, any_col);
		else if (w < 650)
			send_cmd(CMD_PUT_CHAR, CH_BS, any_row, any_col);
		else if (w < 690)
			send_cmd(CMD_PUT_CHAR, CHAR_W'($urandom_range(255)), any_row, any_col);
		else if (w < 810)
			send_cmd(CMD_PUT_AT, CHAR_W'($urandom_range(255)), pick_row(), pick_col());
		else if (w < 990)
			send_cmd(CMD_READ, CHAR_W'($urandom_range(255)), pick_row(), pick_col());
		else if (w < 995)
			send_cmd(CMD_CLEAR, CHAR_W'($urandom_range(255)), any_row, any_col);
		else
			repeat ($urandom_range(28, 18))
				send_cmd(CMD_PUT_CHAR, CH_NL, any_row, any_col);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// store comes out of reset all zero, cursor at home
	task automatic test_reset_state();
		send_cmd(CMD_READ, 8'h00, 5'd0, 7'd0);
		send_cmd(CMD_READ, 8'hFF, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
		send_cmd(CMD_PUT_CHAR, 8'h00, 5'd31, 7'd127);
	endtask

	// printable extremes land with the current attribute; other bytes do nothing
	task automatic test_printable();
		write_reg(REG_FG, 4'hA);
		write_reg(REG_BG, 4'h5);
		send_cmd(CMD_PUT_CHAR, CH_BLANK, 5'd0, 7'd0);
		send_cmd(CMD_PUT_CHAR, 8'h7E, 5'd0, 7'd0);
		send_cmd(CMD_PUT_CHAR, 8'h41, 5'd0, 7'd0);
		send_cmd(CMD_PUT_CHAR, 8'h1F, 5'd0, 7'd0);
		send_cmd(CMD_PUT_CHAR, CH_DEL, 5'd0, 7'd0);
		send_cmd(CMD_PUT_CHAR, 8'h80, 5'd0, 7'd0);
		send_cmd(CMD_PUT_CHAR, 8'hFF, 5'd0, 7'd0);
		send_cmd(CMD_READ, 8'h00, 5'd0, 7'd1);
	endtask

	// backspace mid-row and at column 0, tab padding, newline
	task automatic test_controls();
		send_cmd(CMD_PUT_CHAR, CH_BS, 5'd0, 7'd0);
		send_cmd(CMD_PUT_CHAR, CH_TAB, 5'd0, 7'd0);
		send_cmd(CMD_PUT_CHAR, CH_TAB, 5'd0, 7'd0);
		send_cmd(CMD_READ, 8'h00, 5'd0, 7'd9);
		// pause with nothing in flight before going on
		wait_for_quiet();
		send_cmd(CMD_PUT_CHAR, CH_NL, 5'd0, 7'd0);
		send_cmd(CMD_PUT_CHAR, CH_BS, 5'd0, 7'd0);
		send_cmd(CMD_READ, 8'h00, 5'd1, 7'd0);
	endtask

	// put_at anywhere on and off the screen, cursor untouched
	task automatic test_put_at_read();
		send_cmd(CMD_PUT_AT, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
		send_cmd(CMD_PUT_AT, 8'hFF, 5'd0, 7'd0);
		send_cmd(CMD_PUT_AT, 8'h55, ROW_W'(ROWS), 7'd0);
		send_cmd(CMD_PUT_AT, 8'hAA, 5'd0, COL_W'(COLUMNS));
		send_cmd(CMD_PUT_AT, 8'h33, 5'd31, 7'd127);
		send_cmd(CMD_READ, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
		send_cmd(CMD_READ, 8'h00, 5'd0, 7'd0);
		send_cmd(CMD_READ, 8'h00, 5'd31, 7'd127);
		send_cmd(CMD_READ, 8'h00, ROW_W'(ROWS), 7'd0);
	endtask

	// clear fills with blanks and homes the cursor
	task automatic test_clear();
		send_cmd(CMD_CLEAR, 8'h00, 5'd0, 7'd0);
		send_cmd(CMD_READ, 8'h00, 5'd12, 7'd40);
	endtask

	// drive the cursor to the last row, then scroll by newline and by row end
	task automatic test_wrap_scroll();
		write_reg(REG_FG, 4'h0);
		write_reg(REG_BG, 4'hF);
		while (cur_line < ROWS - 1)
			send_cmd(CMD_PUT_CHAR, CH_NL, 5'd0, 7'd0);
		send_cmd(CMD_PUT_CHAR, CH_NL, 5'd0, 7'd0);
		repeat (COLUMNS / TAB_STOP - 1)
			send_cmd(CMD_PUT_CHAR, CH_TAB, 5'd0, 7'd0);
		repeat (TAB_STOP - 1)
			send_cmd(CMD_PUT_CHAR, 8'h61, 5'd0, 7'd0);
		// this one lands in the last column of the last row
		send_cmd(CMD_PUT_CHAR, 8'h5A, 5'd0, 7'd0);
		send_cmd(CMD_READ, 8'h00, ROW_W'(ROWS - 2), COL_W'(COLUMNS - 1));
		send_cmd(CMD_READ, 8'h00, ROW_W'(ROWS - 1), 7'd0);
	endtask

	// a run of random beats under one colour setting and one idle profile
	task automatic test_random_traffic(int idle_pct, int count, logic [CLR_W-1:0] fg,
			logic [CLR_W-1:0] bg);
		int stop_at;
		write_reg(REG_FG, fg);
		write_reg(REG_BG, bg);
		send_idle_pct = idle_pct;
		stop_at = items_sent + count;
		while (items_sent < stop_at)
			send_random();
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		for (int i = 0; i < CELL_COUNT; i++)
			screen_shadow[i] = '0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		// the clearing pass after reset shows up as busy, so the first beat just waits

		send_idle_pct = 38;
		test_reset_state();
		test_printable();
		test_controls();
		test_put_at_read();
		test_clear();
		test_wrap_scroll();

		test_random_traffic(38, 550, CLR_W'($urandom_range(15)), CLR_W'($urandom_range(15)));
		test_random_traffic(56, 550, 4'hF, 4'h0);
		test_random_traffic(0, 550, CLR_W'($urandom_range(15)), CLR_W'($urandom_range(15)));

		wait_for_quiet();
		// catch any stray strobe after the last result
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (error_count == 0)
			$display("text_console_cell_writer_unit_tb: done, clean");
		else
			$display("text_console_cell_writer_unit_tb: done, errors");
		$finish;
	end

	// time limit, several times the slowest legal run with every beat a scroll
	initial begin
		#(120_000_000);
		$display("text_console_cell_writer_unit_tb: done, errors");
		$finish;
	end

endmodule

### sim.f
rtl/tccw_pkg.sv
rtl/text_console_cell_writer_unit.sv
tb/sv/text_console_cell_writer_unit_tb.sv
